/* rtl/mppt_pkg.sv */
package mppt_pkg;

	// Field widths
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CoordW = 12;
	localparam int unsigned BoundW = 13;
	localparam int unsigned BtnW   = 3;

	// Byte 0 of a packet must have this bit set to be taken as a header
	localparam int unsigned SyncBit = 3;

	// Largest usable screen bound
	localparam logic [BoundW-1:0] MaxBound = 13'd4096;

	// Reset values
	localparam logic [CoordW-1:0] ResetX      = 12'd512;
	localparam logic [CoordW-1:0] ResetY      = 12'd384;
	localparam logic [BoundW-1:0] ResetWidth  = 13'd1024;
	localparam logic [BoundW-1:0] ResetHeight = 13'd768;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_SCREEN_WIDTH  = 1'b0,
		CFG_SCREEN_HEIGHT = 1'b1
	} cfg_idx_t;

	// Position within a three-byte packet
	typedef enum logic [1:0] {
		PKT_HEAD = 2'd0,
		PKT_DX   = 2'd1,
		PKT_DY   = 2'd2
	} pkt_pos_t;

	typedef logic [CoordW-1:0] coord_t;
	typedef logic [BoundW-1:0] bound_t;

endpackage

/* rtl/mppt_clamp.sv */
module mppt_clamp (
	input  mppt_pkg::coord_t  cur,
	input  logic [7:0]        delta,
	input  logic              subtract,
	input  mppt_pkg::bound_t  bound,
	output mppt_pkg::coord_t  coord
);
	import mppt_pkg::*;

	logic signed [CoordW+1:0] cur_ext;
	logic signed [CoordW+1:0] delta_ext;
	logic signed [CoordW+1:0] moved;
	bound_t                   bound_eff;
	bound_t                   bound_m1;

	// Move by a signed 8-bit delta in a 14-bit signed space
	assign cur_ext   = signed'({2'b00, cur});
	assign delta_ext = signed'({{(CoordW-6){delta[7]}}, delta});
	assign moved     = subtract ? (cur_ext - delta_ext) : (cur_ext + delta_ext);

	// Zero bound acts as one, anything above the max acts as the max
	always_comb begin
		if (bound == '0) begin
			bound_eff = BoundW'(1);
		end else if (bound > MaxBound) begin
			bound_eff = MaxBound;
		end else begin
			bound_eff = bound;
		end
	end
	assign bound_m1 = bound_eff - BoundW'(1);

	// Clamp to 0 .. bound - 1
	always_comb begin
		if (moved < 0) begin
			coord = '0;
		end else if (moved[BoundW-1:0] >= bound_eff) begin
			coord = bound_m1[CoordW-1:0];
		end else begin
			coord = moved[CoordW-1:0];
		end
	end

endmodule

/* rtl/mouse_packet_position_tracker.sv */
// Mouse packet position tracker.
// Slave stream: one received mouse byte per item on s_tdata. Bytes are gathered
// into three-byte packets; while waiting for a header, a byte with bit 3 clear
// is dropped (m_tuser bit 1 set) so the stream can regain sync. The third byte
// updates buttons and moves the cursor (x minus dx, y plus dy), clamped to the
// configured screen bounds (m_tuser bit 0 set).
// Master stream: exactly one result item per input item, carrying the cursor
// and button state after that byte.
// Config channel: cfg_index 0 = screen width, 1 = screen height; cfg_ready is
// always high. Write only while no item is in flight.
// m_tvalid rises in the cycle after input accept. Throughput: one item per cycle
// while m_tready is high; the add and clamp sit between the input port and the result register.
// When the receiver stalls, the result register holds and s_tready follows
// m_tready, so a new item is taken in the same cycle the result is taken.
// Reset: cursor at (512, 384), buttons clear, width 1024, height 768, packet
// position at the header byte, no result pending.
module mouse_packet_position_tracker (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [11:0] pos_x, [23:12] pos_y, [26:24] button_bits
	output logic [1:0]  m_tuser   // [0] packet_done, [1] byte_dropped
);
	import mppt_pkg::*;

	bound_t                width_q;
	bound_t                height_q;
	pkt_pos_t              pos_q;
	logic [ByteW-1:0]      head_q;
	logic [ByteW-1:0]      dx_q;
	coord_t                cur_x_q;
	coord_t                cur_y_q;
	logic [BtnW-1:0]       btn_q;

	logic                  res_valid_q;
	coord_t                res_x_q;
	coord_t                res_y_q;
	logic [BtnW-1:0]       res_btn_q;
	logic                  res_done_q;
	logic                  res_drop_q;

	logic                  accept;
	logic [ByteW-1:0]      rx_byte;
	coord_t                new_x;
	coord_t                new_y;
	pkt_pos_t              pos_d;
	logic                  done_d;
	logic                  drop_d;

	assign cfg_ready = 1'b1;
	assign s_tready  = !res_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign rx_byte   = s_tdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ResetWidth;
			height_q <= ResetHeight;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SCREEN_WIDTH:  width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Cursor moves: x against dx, y with dy
	mppt_clamp u_clamp_x (
		.cur      (cur_x_q),
		.delta    (dx_q),
		.subtract (1'b1),
		.bound    (width_q),
		.coord    (new_x)
	);

	mppt_clamp u_clamp_y (
		.cur      (cur_y_q),
		.delta    (rx_byte),
		.subtract (1'b0),
		.bound    (height_q),
		.coord    (new_y)
	);

	// Packet position sequencing
	always_comb begin
		pos_d  = pos_q;
		done_d = 1'b0;
		drop_d = 1'b0;
		unique case (pos_q)
			PKT_HEAD: begin
				if (rx_byte[SyncBit]) begin
					pos_d = PKT_DX;
				end else begin
					drop_d = 1'b1;
				end
			end
			PKT_DX: pos_d = PKT_DY;
			default: begin
				pos_d  = PKT_HEAD;
				done_d = 1'b1;
			end
		endcase
	end

	// Packet state and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= PKT_HEAD;
			head_q  <= '0;
			dx_q    <= '0;
			cur_x_q <= ResetX;
			cur_y_q <= ResetY;
			btn_q   <= '0;
		end else if (accept) begin
			pos_q <= pos_d;
			if (pos_q == PKT_HEAD && rx_byte[SyncBit]) begin
				head_q <= rx_byte;
			end
			if (pos_q == PKT_DX) begin
				dx_q <= rx_byte;
			end
			if (done_d) begin
				cur_x_q <= new_x;
				cur_y_q <= new_y;
				btn_q   <= head_q[BtnW-1:0];
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_x_q    <= done_d ? new_x : cur_x_q;
			res_y_q    <= done_d ? new_y : cur_y_q;
			res_btn_q  <= done_d ? head_q[BtnW-1:0] : btn_q;
			res_done_q <= done_d;
			res_drop_q <= drop_d;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {5'b0, res_btn_q, res_y_q, res_x_q};
	assign m_tuser  = {res_drop_q, res_done_q};

`ifndef ASSERT_OFF
	a_done_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("packet_done and byte_dropped both set");

	a_pos_legal: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3)
		else $error("packet position out of range");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted item produced no result");

	a_drop_only_at_head: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos_q != PKT_HEAD |=> !m_tuser[1])
		else $error("byte dropped outside header position");
`endif

endmodule

/* sim/mouse_packet_position_tracker_tb.sv */
`timescale 1ns / 1ps

module mouse_packet_position_tracker_tb;
	import mppt_pkg::*;

	// One result item as seen on the master stream
	typedef struct packed {
		coord_t          x;
		coord_t          y;
		logic [BtnW-1:0] btn;
		logic            done;
		logic            dropped;
	} cursor_report_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [0:0]        cfg_index;
	logic [BoundW-1:0] cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // [7:0] rx_byte
	logic              m_tvalid;
	logic              m_tready;
	logic [31:0]       m_tdata;   // [11:0] pos_x, [23:12] pos_y, [26:24] button_bits
	logic [1:0]        m_tuser;   // [0] packet_done, [1] byte_dropped

	// Tracker copy of the block state
	pkt_pos_t        pkt_pos;
	logic [7:0]      head_q;
	logic [7:0]      dx_q;
	coord_t          cur_x;
	coord_t          cur_y;
	logic [BtnW-1:0] btn_q;
	bound_t          width_q;
	bound_t          height_q;

	cursor_report_t pending_reports[$];
	int             mismatch_cnt;
	bit             src_idle_en;
	bit             snk_idle_en;

	mouse_packet_position_tracker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Zero bound acts as 1, oversized bound acts as MaxBound (4096)
	function automatic coord_t clamp_coord(int v, bound_t lim);
		int top;
		top = (lim == '0) ? 1 : (lim > MaxBound) ? int'(MaxBound) : int'(lim);
		if (v < 0)
			return '0;
		if (v >= top)
			return coord_t'(top - 1);
		return coord_t'(v);
	endfunction

	// Advance the packet tracker by one byte and return the expected item
	function automatic cursor_report_t track_byte(logic [7:0] b);
		cursor_report_t r;
		int dx;
		int dy;
		r.done = 1'b0;
		r.dropped = 1'b0;
		case (pkt_pos)
			PKT_HEAD: begin
				if (!b[SyncBit]) begin
					r.dropped = 1'b1;
				end else begin
					head_q = b;
					pkt_pos = PKT_DX;
				end
			end
			PKT_DX: begin
				dx_q = b;
				pkt_pos = PKT_DY;
			end
			default: begin
				dx = $signed(dx_q);
				dy = $signed(b);
				btn_q = head_q[BtnW-1:0];
				cur_x = clamp_coord(int'(cur_x) - dx, width_q);
				cur_y = clamp_coord(int'(cur_y) + dy, height_q);
				pkt_pos = PKT_HEAD;
				r.done = 1'b1;
			end
		endcase
		r.x = cur_x;
		r.y = cur_y;
		r.btn = btn_q;
		return r;
	endfunction

	// Send one byte, record its expected result
	task automatic send_byte(input logic [7:0] b, output bit dropped);
		int gap;
		cursor_report_t r;
		gap = src_idle_en ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		r = track_byte(b);
		pending_reports.push_back(r);
		dropped = r.dropped;
	endtask

	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
			input logic [7:0] dy);
		bit dr;
		send_byte(hdr, dr);
		send_byte(dx, dr);
		send_byte(dy, dr);
	endtask

	// Stop sending and let all results come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_bound(input cfg_idx_t idx, input bound_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_SCREEN_WIDTH)
			width_q = val;
		else
			height_q = val;
		@(posedge clk);
	endtask

	task automatic set_screen(input bound_t w, input bound_t h);
		wait_idle();
		write_bound(CFG_SCREEN_WIDTH, w);
		write_bound(CFG_SCREEN_HEIGHT, h);
	endtask

	// Headers without the sync bit are discarded at reset bounds
	task automatic test_sync_drop();
		bit dr;
		send_byte(8'h00, dr);
		send_byte(8'hF7, dr);
	endtask

	// Full-scale deltas in both directions, button states 7, 1 and 2
	task automatic test_packets();
		send_packet(8'hFF, 8'h80, 8'h7F);
		send_packet(8'h09, 8'h7F, 8'h80);
		send_packet(8'h0A, 8'h00, 8'h00);
	endtask

	// Zero, one and oversized screen bounds
	task automatic test_bounds();
		set_screen(13'd0, 13'h1FFF);
		send_packet(8'h0C, 8'h80, 8'h7F);
		set_screen(13'h1FFF, 13'd1);
		send_packet(8'h08, 8'h80, 8'h7F);
		set_screen(MaxBound, MaxBound + 13'd1);
		send_packet(8'h0B, 8'h7F, 8'h80);
	endtask

	// Random packets with noise, under one screen setting
	task automatic run_phase(input bound_t w, input bound_t h, input int target);
		int counted;
		int chunk;
		int drift;
		logic [7:0] hdr;
		logic [7:0] dx;
		logic [7:0] dy;
		bit dr;
		set_screen(w, h);
		counted = 0;
		chunk = 0;
		drift = 0;
		while (counted < target) begin
			if (chunk == 0) begin
				chunk = $urandom_range(10, 60);
				src_idle_en = ($urandom_range(0, 3) != 0);
				snk_idle_en = ($urandom_range(0, 3) != 0);
				// 0: free walk, 1: toward max corner, 2: toward zero corner
				drift = $urandom_range(0, 2);
			end
			chunk--;
			if ($urandom_range(0, 99) < 85) begin
				// resync after noise with filler bytes
				while (pkt_pos != PKT_HEAD) begin
					send_byte(8'($urandom), dr);
					counted++;
				end
				hdr = 8'($urandom);
				hdr[SyncBit] = 1'b1;
				dx = 8'($urandom);
				dy = 8'($urandom);
				if (drift == 1) begin
					dx[7] = 1'b1;
					dy[7] = 1'b0;
				end else if (drift == 2) begin
					dx[7] = 1'b0;
					dy[7] = 1'b1;
				end
				send_packet(hdr, dx, dy);
				counted += 3;
			end else begin
				repeat ($urandom_range(1, 2)) begin
					send_byte(8'($urandom), dr);
					if (!dr)
						counted++;
				end
			end
		end
	endtask

	task automatic test_random();
		run_phase(ResetWidth, ResetHeight, 260);
		run_phase(13'h1FFF, 13'd0, 200);
		run_phase(13'd1, 13'd2, 160);
		run_phase(MaxBound, MaxBound, 330);
		run_phase(13'd640, 13'd480, 260);
		run_phase(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)), 200);
		run_phase(MaxBound + 13'd1, 13'd33, 140);
	endtask

	// Result checker with random receiver stalls
	initial begin : sink
		int gap;
		cursor_report_t want;
		cursor_report_t got;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = snk_idle_en ? $urandom_range(0, 4) : 0;
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.x = m_tdata[11:0];
			got.y = m_tdata[23:12];
			got.btn = m_tdata[26:24];
			got.done = m_tuser[0];
			got.dropped = m_tuser[1];
			if (pending_reports.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected item: x=%0d y=%0d btn=%0d done=%0b drop=%0b",
						got.x, got.y, got.btn, got.done, got.dropped);
			end else begin
				want = pending_reports.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display({"item differs: exp x=%0d y=%0d btn=%0d done=%0b drop=%0b",
							" got x=%0d y=%0d btn=%0d done=%0b drop=%0b"},
							want.x, want.y, want.btn, want.done, want.dropped,
							got.x, got.y, got.btn, got.done, got.dropped);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("mouse_packet_position_tracker: mismatch");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		mismatch_cnt = 0;
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		pkt_pos = PKT_HEAD;
		head_q = '0;
		dx_q = '0;
		cur_x = ResetX;
		cur_y = ResetY;
		btn_q = '0;
		width_q = ResetWidth;
		height_q = ResetHeight;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sync_drop();
		test_packets();
		test_bounds();
		test_random();

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("mouse_packet_position_tracker: match");
		else
			$display("mouse_packet_position_tracker: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
rtl/mppt_pkg.sv
rtl/mppt_clamp.sv
rtl/mouse_packet_position_tracker.sv
sim/mouse_packet_position_tracker_tb.sv
